// ===== hdl/htd_pkg.sv =====
// shared types, codes and constants of the huffman tree decoder
`default_nettype none
package htd_pkg;

   // defaults for the top-level parameters
   localparam int TREE_NODES_DEF  = 255;
   localparam int LENGTH_BITS_DEF = 20;

   // fixed field widths
   localparam int CFG_BITS    = 20;
   localparam int NODE_BITS   = 8;
   localparam int BRANCH_BITS = 9;
   localparam int ENTRY_BITS  = 2 * BRANCH_BITS;

   // walk starts here after a start beat and after every leaf
   localparam logic [NODE_BITS-1:0] HEAD_NODE = 8'd254;
   // bit of a byte that is walked last
   localparam logic [2:0] TOP_BIT_POS = 3'd7;

   // item kinds
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;

   typedef struct packed {
      logic [1:0]             kind;
      logic [NODE_BITS-1:0]   node_index;
      logic [BRANCH_BITS-1:0] branch_zero;
      logic [BRANCH_BITS-1:0] branch_one;
      logic [7:0]             data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
      logic       error;
   } rsp_type;

   // access to the node store, one write and one read per cycle
   typedef struct packed {
      logic                  wr_en;
      logic [NODE_BITS-1:0]  wr_node;
      logic [ENTRY_BITS-1:0] wr_data;
      logic                  rd_en;
      logic [NODE_BITS-1:0]  rd_node;
   } mem_req_type;

   // result handed from the walker to the output register
   typedef struct packed {
      logic    push;
      rsp_type rsp;
   } emit_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

endpackage
`default_nettype wire

// ===== hdl/htd_tree_mem.sv =====
// node store of the decoding tree, one write and one registered read port
`default_nettype none
module htd_tree_mem #(
   parameter int TREE_NODES = htd_pkg::TREE_NODES_DEF
) (
   input  wire                                 clock,
   input  htd_pkg::mem_req_type                mem_req,
   output logic [htd_pkg::ENTRY_BITS-1:0]      rd_data
);

   localparam int IDX_BITS = $clog2(TREE_NODES);

   logic [htd_pkg::ENTRY_BITS-1:0] tree_mem [TREE_NODES];
   logic [htd_pkg::ENTRY_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         tree_mem[mem_req.wr_node[IDX_BITS-1:0]] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= tree_mem[mem_req.rd_node[IDX_BITS-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/htd_walk.sv =====
// item sequencer and bit-serial tree walker
`default_nettype none
module htd_walk #(
   parameter int TREE_NODES  = htd_pkg::TREE_NODES_DEF,
   parameter int LENGTH_BITS = htd_pkg::LENGTH_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  htd_pkg::req_type                    req_data,
   input  wire                                 csr_valid,
   input  wire  [htd_pkg::CFG_BITS-1:0]        csr_data,
   output htd_pkg::mem_req_type                mem_req,
   input  wire  [htd_pkg::ENTRY_BITS-1:0]      rd_data,
   input  wire                                 out_free,
   output htd_pkg::emit_type                   emit
);

   localparam logic [htd_pkg::BRANCH_BITS-1:0] NODE_LIMIT = 9'(TREE_NODES);
   localparam logic [LENGTH_BITS-1:0]          ONE_LEFT   = LENGTH_BITS'(1);

   htd_pkg::state_type state_ff, state_in;
   logic [htd_pkg::NODE_BITS-1:0] node_ff, node_in;
   logic [LENGTH_BITS-1:0]        left_ff, left_in;
   logic [LENGTH_BITS-1:0]        length_ff, length_in;
   logic                          active_ff, active_in;
   logic [7:0]                    byte_ff, byte_in;
   logic [2:0]                    bit_ff, bit_in;

   logic                             accept;
   logic                             walking;
   logic [htd_pkg::BRANCH_BITS-1:0]  branch;
   logic                             head_bad;
   logic                             is_leaf;
   logic                             tgt_bad;
   logic                             err;
   logic                             want_emit;
   logic                             stall;
   logic                             advance;
   logic                             final_sym;
   logic                             chunk_done;
   logic                             byte_done;
   logic [htd_pkg::NODE_BITS-1:0]    node_next;
   logic [htd_pkg::NODE_BITS-1:0]    rd_node;

   assign req_ready = (state_ff == htd_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign walking   = (state_ff == htd_pkg::ST_WALK);

   // one tree step for the current bit
   assign head_bad  = {1'b0, node_ff} >= NODE_LIMIT;
   assign branch    = byte_ff[bit_ff] ? rd_data[htd_pkg::ENTRY_BITS-1:htd_pkg::BRANCH_BITS]
                                      : rd_data[htd_pkg::BRANCH_BITS-1:0];
   assign is_leaf   = !branch[htd_pkg::BRANCH_BITS-1];
   assign tgt_bad   = {1'b0, branch[htd_pkg::NODE_BITS-1:0]} >= NODE_LIMIT;
   assign err       = head_bad || (!is_leaf && tgt_bad);
   assign want_emit = err || is_leaf;
   assign stall     = want_emit && !out_free;
   assign advance   = walking && !stall;
   assign final_sym = !err && is_leaf && (left_ff == ONE_LEFT);
   assign chunk_done = err || final_sym;
   assign byte_done  = chunk_done || (bit_ff == htd_pkg::TOP_BIT_POS);

   always_comb begin
      if (err) begin
         node_next = node_ff;
      end else if (is_leaf) begin
         node_next = htd_pkg::HEAD_NODE;
      end else begin
         node_next = branch[htd_pkg::NODE_BITS-1:0];
      end
   end

   // read the node needed next cycle
   assign rd_node = advance ? node_next : node_ff;

   always_comb begin
      mem_req.wr_en   = accept && (req_data.kind == htd_pkg::KIND_LOAD) &&
                        ({1'b0, req_data.node_index} < NODE_LIMIT);
      mem_req.wr_node = req_data.node_index;
      mem_req.wr_data = {req_data.branch_one, req_data.branch_zero};
      mem_req.rd_en   = {1'b0, rd_node} < NODE_LIMIT;
      mem_req.rd_node = rd_node;
   end

   always_comb begin
      emit.push       = walking && want_emit && out_free;
      emit.rsp.symbol = err ? 8'd0 : branch[7:0];
      emit.rsp.last   = final_sym;
      emit.rsp.error  = err;
   end

   always_comb begin
      state_in  = state_ff;
      node_in   = node_ff;
      left_in   = left_ff;
      active_in = active_ff;
      byte_in   = byte_ff;
      bit_in    = bit_ff;
      length_in = csr_valid ? LENGTH_BITS'(csr_data) : length_ff;
      case (state_ff)
         htd_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  htd_pkg::KIND_START: begin
                     node_in   = htd_pkg::HEAD_NODE;
                     left_in   = length_ff;
                     active_in = (length_ff != '0);
                  end
                  htd_pkg::KIND_DATA: begin
                     if (active_ff) begin
                        state_in = htd_pkg::ST_WALK;
                        byte_in  = req_data.data_byte;
                        bit_in   = 3'd0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         htd_pkg::ST_WALK: begin
            if (advance) begin
               node_in = node_next;
               bit_in  = bit_ff + 3'd1;
               if (!err && is_leaf) begin
                  left_in = left_ff - ONE_LEFT;
               end
               if (chunk_done) begin
                  active_in = 1'b0;
               end
               if (byte_done) begin
                  state_in = htd_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = htd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= htd_pkg::ST_IDLE;
         node_ff   <= htd_pkg::HEAD_NODE;
         left_ff   <= '0;
         active_ff <= 1'b0;
         length_ff <= '0;
      end else begin
         state_ff  <= state_in;
         node_ff   <= node_in;
         left_ff   <= left_in;
         active_ff <= active_in;
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      bit_ff  <= bit_in;
   end

endmodule
`default_nettype wire

// ===== hdl/htd_out.sv =====
// output register between the walker and the result channel
`default_nettype none
module htd_out (
   input  wire                 clock,
   input  wire                 reset,
   input  htd_pkg::emit_type   emit,
   output logic                out_free,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output htd_pkg::rsp_type    rsp_data
);

   logic             rsp_valid_ff, rsp_valid_in;
   htd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit.push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit.rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== hdl/huffman_tree_decoder.sv =====
// top level of the huffman tree decoder
`default_nettype none
// Huffman decoder driven by a binary node table held in a single-port-read
// synchronous memory. Load beats write one node (two 9-bit branches, below
// 256 a leaf symbol, otherwise a pointer to node value minus 256); a start
// beat returns the walk to head node 254 and arms a chunk of output_length
// symbols (a length of zero arms nothing). Data bytes are walked least
// significant bit first, one node read per bit, one bit per cycle while the
// result side keeps up. A data byte is taken and then walked bit by bit; no
// further item is taken until the walk of the byte ends, after its top bit
// or earlier when the chunk ends inside the byte. The bit rate is set by the
// dependent chain of node reads through the one read port: each step's
// address comes from the previous step's data. Results leave through an
// output register, so a stalled result side holds the walk only when a
// symbol or error beat is due. A branch pointing outside the table gives one
// error beat and ends the chunk. Never-loaded nodes read as garbage.
// csr_data is sampled by the next start beat; write it only while idle.
module huffman_tree_decoder #(
   parameter int TREE_NODES  = htd_pkg::TREE_NODES_DEF,
   parameter int LENGTH_BITS = htd_pkg::LENGTH_BITS_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   // item channel
   input  wire                             req_valid,
   output logic                            req_ready,
   input  htd_pkg::req_type                req_data,
   // result channel
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output htd_pkg::rsp_type                rsp_data,
   // output length register write
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [htd_pkg::CFG_BITS-1:0]    csr_data
);

   htd_pkg::mem_req_type               mem_req;
   logic [htd_pkg::ENTRY_BITS-1:0]     rd_data;
   htd_pkg::emit_type                  emit;
   logic                               out_free;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // sequencer and walker, owns the walk state and the length register
   htd_walk #(
      .TREE_NODES  (TREE_NODES),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .out_free  (out_free),
      .emit      (emit)
   );

   // node table, read data is registered and arrives in the cycle after the address
   htd_tree_mem #(
      .TREE_NODES (TREE_NODES)
   ) u_tree_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // result beat register
   htd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the huffman tree decoder
module testbench;

   localparam int NODE_COUNT    = htd_pkg::TREE_NODES_DEF;
   localparam int LEAF_LIMIT    = 256;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int QUIET_CYCLES  = 24;
   localparam int PRINT_LIMIT   = 100;
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam logic [8:0] BAD_BRANCH = 9'd511;

   typedef struct packed {
      logic [htd_pkg::BRANCH_BITS-1:0] one;
      logic [htd_pkg::BRANCH_BITS-1:0] zero;
   } node_pair_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   htd_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   htd_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [htd_pkg::CFG_BITS-1:0] csr_data = '0;

   // items waiting for the driver, symbols waiting for the result channel
   htd_pkg::req_type items_to_send [$];
   htd_pkg::rsp_type symbols_due [$];

   // decoder state as the predictor sees it
   node_pair_type                 node_table [NODE_COUNT];
   logic [htd_pkg::NODE_BITS-1:0] walk_node    = htd_pkg::HEAD_NODE;
   logic [htd_pkg::CFG_BITS-1:0]  symbols_left = '0;
   logic                          walk_armed   = 1'b0;
   logic [htd_pkg::CFG_BITS-1:0]  chunk_length = '0;

   // nodes the stimulus has loaded so far; walks may only reach these
   bit node_loaded [NODE_COUNT];
   int loaded_nodes [$];

   bit      req_beat  = 1'b0;
   bit      steady    = 1'b0;
   int      req_gap   = 0;
   int      rsp_stall = 0;
   int      error_count = 0;
   int      cycle_count = 0;
   htd_pkg::rsp_type want;

   huffman_tree_decoder DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   task automatic flag_error(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
      error_count++;
   endtask

   // expected symbols of one accepted item
   task automatic decode_item(input htd_pkg::req_type item);
      logic [htd_pkg::BRANCH_BITS-1:0] branch;
      htd_pkg::rsp_type sym;
      int b;
      case (item.kind)
         htd_pkg::KIND_LOAD: begin
            if (item.node_index < NODE_COUNT) begin
               node_table[item.node_index].zero = item.branch_zero;
               node_table[item.node_index].one  = item.branch_one;
            end
         end
         htd_pkg::KIND_START: begin
            walk_node    = htd_pkg::HEAD_NODE;
            symbols_left = chunk_length;
            walk_armed   = chunk_length != 0;
         end
         htd_pkg::KIND_DATA: begin
            // lsb first; the loop stops as soon as the chunk ends
            for (b = 0; b < 8 && walk_armed; b++) begin
               sym = '0;
               if (walk_node >= NODE_COUNT) begin
                  // head outside the table, only with a shrunk table
                  sym.error = 1'b1;
                  symbols_due.push_back(sym);
                  walk_armed = 1'b0;
               end else begin
                  branch = item.data_byte[b] ? node_table[walk_node].one
                                             : node_table[walk_node].zero;
                  if (branch < LEAF_LIMIT) begin
                     symbols_left = symbols_left - 1'b1;
                     sym.symbol = branch[7:0];
                     sym.last   = symbols_left == 0;
                     symbols_due.push_back(sym);
                     walk_node = htd_pkg::HEAD_NODE;
                     if (symbols_left == 0) begin
                        walk_armed = 1'b0;
                     end
                  end else if (branch - LEAF_LIMIT >= NODE_COUNT) begin
                     sym.error = 1'b1;
                     symbols_due.push_back(sym);
                     walk_armed = 1'b0;
                  end else begin
                     walk_node = branch[7:0];
                  end
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   // driver: both channels change at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_beat) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (!steady && $urandom_range(0, 9) == 0) begin
               req_gap = $urandom_range(1, 17) - 1;
               req_valid <= 1'b0;
            end else if (items_to_send.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= items_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else if (!steady && $urandom_range(0, 11) == 0) begin
            rsp_stall = $urandom_range(1, 17) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: beats are taken at the rising edge
   always @(posedge clock) begin
      req_beat = req_valid && req_ready;
      if (reset) begin
         walk_node    = htd_pkg::HEAD_NODE;
         symbols_left = '0;
         walk_armed   = 1'b0;
         chunk_length = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            chunk_length = csr_data;
         end
         if (req_beat) begin
            decode_item(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (symbols_due.size() == 0) begin
               flag_error($sformatf("unexpected beat %h", rsp_data));
            end else begin
               want = symbols_due.pop_front();
               if (rsp_data.symbol !== want.symbol) begin
                  flag_error($sformatf("symbol %h, want %h", rsp_data.symbol, want.symbol));
               end
               if (rsp_data.last !== want.last) begin
                  flag_error($sformatf("last %b, want %b", rsp_data.last, want.last));
               end
               if (rsp_data.error !== want.error) begin
                  flag_error($sformatf("error %b, want %b", rsp_data.error, want.error));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[huffman_tree_decoder] ERROR");
         $finish;
      end
   end

   function automatic void note_loaded(input int idx);
      if (idx < NODE_COUNT && !node_loaded[idx]) begin
         node_loaded[idx] = 1'b1;
         loaded_nodes.push_back(idx);
      end
   endfunction

   task automatic queue_item(input logic [1:0] kind, input logic [7:0] idx,
                             input logic [8:0] zero_val, input logic [8:0] one_val,
                             input logic [7:0] byte_val);
      htd_pkg::req_type it;
      it.kind        = kind;
      it.node_index  = idx;
      it.branch_zero = zero_val;
      it.branch_one  = one_val;
      it.data_byte   = byte_val;
      if (kind == htd_pkg::KIND_LOAD) begin
         note_loaded(idx);
      end
      items_to_send.push_back(it);
   endtask

   // leaf, pointer to a loaded node, or now and then a bad branch
   function automatic logic [8:0] pick_branch();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) begin
         return BAD_BRANCH;
      end
      if (r < 45) begin
         return {1'b1, 8'(loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)])};
      end
      return 9'($urandom_range(0, 255));
   endfunction

   // block is idle: nothing queued, nothing in flight, walk given time to finish
   task automatic drain();
      while (items_to_send.size() != 0 || req_valid || symbols_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [htd_pkg::CFG_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [htd_pkg::CFG_BITS-1:0] phase_length [6];
      int phase_items [6];
      int p;
      int done;
      int r;
      int idx;
      phase_length = '{20'd1, 20'($urandom_range(2, 12)), 20'd0, 20'hFFFFF,
                       20'($urandom_range(13, 40)), 20'($urandom_range(2, 20))};
      phase_items = '{25, 25, 10, 25, 25, 25};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no chunk yet, spare kind, load past the table: all ignored
      queue_item(htd_pkg::KIND_DATA, 8'h00, 9'd0, 9'd0, 8'hFF);
      queue_item(KIND_SPARE, 8'hFF, 9'h1FF, 9'h1FF, 8'hFF);
      queue_item(htd_pkg::KIND_LOAD, 8'hFF, 9'h1FF, 9'h1FF, 8'hFF);
      // small tree: head goes to node 0 on a zero, leaf 255 on a one;
      // node 0 gives leaf 0 on a zero and a bad branch on a one
      queue_item(htd_pkg::KIND_LOAD, 8'd0, 9'd0, BAD_BRANCH, 8'h00);
      queue_item(htd_pkg::KIND_LOAD, htd_pkg::HEAD_NODE, {1'b1, 8'd0}, 9'd255, 8'h00);
      // length still zero after reset, so the start arms nothing
      queue_item(htd_pkg::KIND_START, 8'h00, 9'd0, 9'd0, 8'h00);
      queue_item(htd_pkg::KIND_DATA, 8'h00, 9'd0, 9'd0, 8'h00);
      drain();

      write_length(20'd3);
      // chunk ends inside the byte, later bytes dropped
      queue_item(htd_pkg::KIND_START, 8'h00, 9'd0, 9'd0, 8'h00);
      queue_item(htd_pkg::KIND_DATA, 8'h00, 9'd0, 9'd0, 8'hFF);
      queue_item(htd_pkg::KIND_DATA, 8'h00, 9'd0, 9'd0, 8'h00);
      queue_item(htd_pkg::KIND_START, 8'h00, 9'd0, 9'd0, 8'h00);
      queue_item(htd_pkg::KIND_DATA, 8'h00, 9'd0, 9'd0, 8'h00);
      // bad branch on the second bit
      queue_item(htd_pkg::KIND_START, 8'h00, 9'd0, 9'd0, 8'h00);
      queue_item(htd_pkg::KIND_DATA, 8'h00, 9'd0, 9'd0, 8'h02);
      queue_item(htd_pkg::KIND_DATA, 8'h00, 9'd0, 9'd0, 8'h55);
      drain();

      write_length(20'hFFFFF);
      // byte ends mid-walk at node 0, then a restart drops that position
      queue_item(htd_pkg::KIND_START, 8'h00, 9'd0, 9'd0, 8'h00);
      queue_item(htd_pkg::KIND_DATA, 8'h00, 9'd0, 9'd0, 8'h01);
      queue_item(htd_pkg::KIND_START, 8'h00, 9'd0, 9'd0, 8'h00);
      queue_item(htd_pkg::KIND_DATA, 8'h00, 9'd0, 9'd0, 8'h00);
      // loads in the middle of a chunk, head rewritten
      queue_item(htd_pkg::KIND_LOAD, 8'd1, 9'h05A, {1'b1, htd_pkg::HEAD_NODE}, 8'h00);
      queue_item(htd_pkg::KIND_LOAD, htd_pkg::HEAD_NODE, {1'b1, 8'd1}, {1'b1, 8'd0},
                 8'h00);
      queue_item(htd_pkg::KIND_DATA, 8'h00, 9'd0, 9'd0, 8'hC6);
      queue_item(htd_pkg::KIND_DATA, 8'h00, 9'd0, 9'd0, 8'h39);

      for (p = 0; p < 6; p++) begin
         drain();
         write_length(phase_length[p]);
         if (p == 5) begin
            steady = 1'b1;
         end
         queue_item(htd_pkg::KIND_START, 8'($urandom), 9'($urandom), 9'($urandom),
                    8'($urandom));
         done = 0;
         while (done < phase_items[p]) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               idx = ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(0, NODE_COUNT - 1);
               if (idx < NODE_COUNT) begin
                  // mark first so a node may point at itself
                  note_loaded(idx);
                  queue_item(htd_pkg::KIND_LOAD, 8'(idx), pick_branch(), pick_branch(),
                             8'($urandom));
                  done++;
               end else begin
                  queue_item(htd_pkg::KIND_LOAD, 8'(idx), 9'($urandom), 9'($urandom),
                             8'($urandom));
               end
            end else if (r < 18) begin
               queue_item(htd_pkg::KIND_START, 8'($urandom), 9'($urandom), 9'($urandom),
                          8'($urandom));
               done++;
            end else if (r < 22) begin
               queue_item(KIND_SPARE, 8'($urandom), 9'($urandom), 9'($urandom),
                          8'($urandom));
            end else begin
               queue_item(htd_pkg::KIND_DATA, 8'($urandom), 9'($urandom), 9'($urandom),
                          8'($urandom));
               done++;
            end
         end
      end
      drain();

      if (error_count == 0) begin
         $display("[huffman_tree_decoder] OK");
      end else begin
         $display("[huffman_tree_decoder] ERROR");
      end
      $finish;
   end

endmodule
